// ----- sv/ptmu_pkg.sv -----
// ----------------------------------------------------------------------------
// ptmu_pkg: shared types and constants of the page table map/unmap block
// Store geometry, entry layout, operation and status codes, and the command
// and status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ptmu_pkg;

  // Store geometry.
  localparam int unsigned NUM_FRAMES        = 16;
  localparam int unsigned ENTRIES_PER_FRAME = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned FRAME_W           = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned ADDR_W            = FRAME_W + IDX_W;
  localparam int unsigned STORE_DEPTH       = NUM_FRAMES * ENTRIES_PER_FRAME;

  // Field widths.
  localparam int unsigned VA_W      = 48;
  localparam int unsigned PA_W      = 52;
  localparam int unsigned ENTRY_W   = 64;
  localparam int unsigned EFRAME_W  = 40;
  localparam int unsigned NEXT_W    = 5;
  localparam int unsigned ROOT_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 5;

  // Allocator limits and reset values.
  localparam logic [NEXT_W-1:0] NEXT_FRAME_TOP   = 5'd31;
  localparam logic [NEXT_W-1:0] FIRST_FREE_RESET = 5'd1;
  localparam logic [ROOT_W-1:0] ROOT_RESET       = 4'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

  // Operation codes.
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  // Walk levels.
  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear_step;
    logic    load_req;
    logic    read_en;
    logic    alloc;
    logic    zero_step;
    logic    link;
    logic    descend;
    logic    leaf_write;
    logic    set_status;
    status_e status;
    logic    out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_ok;
    logic present;
    logic frame_ok;
    logic exhausted;
    logic unmap;
    logic leaf_level;
    logic zero_done;
    logic clear_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/ptmu_req_if.sv -----
// ----------------------------------------------------------------------------
// ptmu_req_if: request channel of the page table map/unmap block
// Valid/ready handshake carrying one map or unmap request.
// ----------------------------------------------------------------------------
interface ptmu_req_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [ptmu_pkg::VA_W-1:0] vaddr;
  logic [ptmu_pkg::PA_W-1:0] paddr;

  modport source (output valid, output operation, output vaddr, output paddr,
                  input ready);
  modport sink   (input valid, input operation, input vaddr, input paddr,
                  output ready);
endinterface

// ----- sv/ptmu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ptmu_rsp_if: response channel of the page table map/unmap block
// Valid/ready handshake carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface ptmu_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [ptmu_pkg::PA_W-1:0] old_phys;
  logic [1:0]                tables_made;
  logic                      invalidate_page;

  modport source (output valid, output status, output old_phys, output tables_made,
                  output invalidate_page, input ready);
  modport sink   (input valid, input status, input old_phys, input tables_made,
                  input invalidate_page, output ready);
endinterface

// ----- sv/ptmu_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptmu_ctrl: walk controller
// One-hot state machine that sequences the store clear, the four-level walk,
// table allocation with zeroing, leaf update and result hand-off.
// ----------------------------------------------------------------------------
module ptmu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  ptmu_pkg::dp_stat_t   stat_i,
  output ptmu_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_START  = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_EVAL   = 8'b0001_0000,
    S_ZERO   = 8'b0010_0000,
    S_LINK   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ptmu_pkg::ST_DONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        if (stat_i.root_ok) begin
          state_d = S_READ;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ptmu_pkg::ST_ABSENT;
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        cmd_o.read_en = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        priority if (stat_i.leaf_level) begin
          cmd_o.leaf_write = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ptmu_pkg::ST_DONE;
          state_d = S_FINISH;
        end else if (stat_i.present && stat_i.frame_ok) begin
          cmd_o.descend = 1'b1;
          state_d = S_READ;
        end else if (stat_i.present || stat_i.unmap) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ptmu_pkg::ST_ABSENT;
          state_d = S_FINISH;
        end else if (stat_i.exhausted) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ptmu_pkg::ST_NO_FRAME;
          state_d = S_FINISH;
        end else begin
          cmd_o.alloc = 1'b1;
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd_o.zero_step = 1'b1;
        if (stat_i.zero_done) state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d = S_READ;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/ptmu_dp.sv -----
// ----------------------------------------------------------------------------
// ptmu_dp: walk datapath
// Holds the table store, the request and walk registers, the configuration
// registers, the bump allocator and the result register.
// ----------------------------------------------------------------------------
module ptmu_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptmu_pkg::ctrl_cmd_t               cmd_i,
  output ptmu_pkg::dp_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [ptmu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptmu_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              req_operation_i,
  input  logic [ptmu_pkg::VA_W-1:0]         req_vaddr_i,
  input  logic [ptmu_pkg::PA_W-1:0]         req_paddr_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output ptmu_pkg::status_e                 rsp_status_o,
  output logic [ptmu_pkg::PA_W-1:0]         rsp_old_phys_o,
  output logic [1:0]                        rsp_tables_made_o,
  output logic                              rsp_invalidate_page_o
);

  localparam int unsigned FW = ptmu_pkg::FRAME_W;
  localparam int unsigned AW = ptmu_pkg::ADDR_W;
  localparam int unsigned EW = ptmu_pkg::ENTRY_W;

  // Table store.
  logic [EW-1:0] mem_q [ptmu_pkg::STORE_DEPTH];
  logic [EW-1:0] rd_data_q;

  // Request and walk registers.
  logic                           op_q, op_d;
  logic [ptmu_pkg::VA_W-1:0]      va_q, va_d;
  logic [ptmu_pkg::PA_W-1:0]      pa_q, pa_d;
  logic [1:0]                     level_q, level_d;
  logic [FW-1:0]                  frame_q, frame_d;
  logic [1:0]                     made_q, made_d;
  logic [FW-1:0]                  nf_q, nf_d;
  logic [ptmu_pkg::IDX_W-1:0]     zcnt_q, zcnt_d;
  logic [AW-1:0]                  ccnt_q, ccnt_d;
  ptmu_pkg::status_e              pend_status_q, pend_status_d;

  // Configuration and allocator.
  logic [ptmu_pkg::ROOT_W-1:0]    root_q, root_d;
  logic [ptmu_pkg::NEXT_W-1:0]    next_frame_q, next_frame_d;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  ptmu_pkg::status_e              out_status_q, out_status_d;
  logic [ptmu_pkg::PA_W-1:0]      out_old_q, out_old_d;
  logic [1:0]                     out_made_q, out_made_d;
  logic                           out_inval_q, out_inval_d;

  logic [ptmu_pkg::IDX_W-1:0]     idx;
  logic [ptmu_pkg::EFRAME_W-1:0]  entry_frame;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [EW-1:0]                  mem_wdata;
  logic [AW-1:0]                  walk_addr;

  // Table index of the current level.
  always_comb begin
    unique case (level_q)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign walk_addr   = {frame_q, idx};
  assign entry_frame = rd_data_q[51:12];

  // Status toward the controller.
  always_comb begin
    stat_o.root_ok    = (32'(root_q) < ptmu_pkg::NUM_FRAMES);
    stat_o.present    = rd_data_q[0];
    stat_o.frame_ok   = (entry_frame < ptmu_pkg::EFRAME_W'(ptmu_pkg::NUM_FRAMES));
    stat_o.exhausted  = (32'(next_frame_q) >= ptmu_pkg::NUM_FRAMES) ||
                        (next_frame_q == ptmu_pkg::NEXT_FRAME_TOP);
    stat_o.unmap      = (op_q == ptmu_pkg::OP_UNMAP);
    stat_o.leaf_level = (level_q == ptmu_pkg::LEVEL_LEAF);
    stat_o.zero_done  = (&zcnt_q);
    stat_o.clear_done = (ccnt_q == AW'(ptmu_pkg::STORE_DEPTH - 1));
    stat_o.out_free   = !out_valid_q || rsp_ready_i;
  end

  // Store write port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk_addr;
    mem_wdata = '0;
    priority if (cmd_i.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = ccnt_q;
    end else if (cmd_i.zero_step) begin
      mem_we    = 1'b1;
      mem_waddr = {nf_q, zcnt_q};
    end else if (cmd_i.link) begin
      mem_we          = 1'b1;
      mem_wdata[51:12] = ptmu_pkg::EFRAME_W'(nf_q);
      mem_wdata[1:0]   = 2'b11;
    end else if (cmd_i.leaf_write) begin
      mem_we = 1'b1;
      if (op_q == ptmu_pkg::OP_MAP) begin
        mem_wdata[51:12] = pa_q[51:12];
        mem_wdata[1:0]   = 2'b11;
      end
    end else begin
      mem_we = 1'b0;
    end
  end

  // Store array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.read_en) rd_data_q <= mem_q[walk_addr];
  end

  // Walk register updates.
  always_comb begin
    op_d          = op_q;
    va_d          = va_q;
    pa_d          = pa_q;
    level_d       = level_q;
    frame_d       = frame_q;
    made_d        = made_q;
    nf_d          = nf_q;
    zcnt_d        = zcnt_q;
    ccnt_d        = ccnt_q;
    pend_status_d = pend_status_q;
    if (cmd_i.clear_step) ccnt_d = ccnt_q + AW'(1);
    if (cmd_i.load_req) begin
      op_d    = req_operation_i;
      va_d    = req_vaddr_i;
      pa_d    = req_paddr_i;
      level_d = 2'd0;
      frame_d = FW'(root_q);
      made_d  = 2'd0;
    end
    if (cmd_i.alloc) begin
      nf_d   = FW'(next_frame_q);
      zcnt_d = '0;
    end
    if (cmd_i.zero_step) zcnt_d = zcnt_q + ptmu_pkg::IDX_W'(1);
    if (cmd_i.link) begin
      frame_d = nf_q;
      made_d  = made_q + 2'd1;
      level_d = level_q + 2'd1;
    end
    if (cmd_i.descend) begin
      frame_d = FW'(entry_frame);
      level_d = level_q + 2'd1;
    end
    if (cmd_i.set_status) pend_status_d = cmd_i.status;
  end

  // Configuration writes and allocator advance.
  always_comb begin
    root_d       = root_q;
    next_frame_d = next_frame_q;
    if (cmd_i.alloc) next_frame_d = next_frame_q + ptmu_pkg::NEXT_W'(1);
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptmu_pkg::CFG_ROOT_FRAME: root_d       = cfg_data_i[ptmu_pkg::ROOT_W-1:0];
        ptmu_pkg::CFG_FIRST_FREE: next_frame_d = cfg_data_i[ptmu_pkg::NEXT_W-1:0];
      endcase
    end
  end

  // Result register: loaded at the end of a walk, cleared when taken.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_old_d    = out_old_q;
    out_made_d   = out_made_q;
    out_inval_d  = out_inval_q;
    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = pend_status_q;
      out_old_d    = '0;
      if (pend_status_q == ptmu_pkg::ST_DONE && op_q == ptmu_pkg::OP_UNMAP) begin
        out_old_d[51:12] = entry_frame;
      end
      out_made_d  = (op_q == ptmu_pkg::OP_UNMAP) ? 2'd0 : made_q;
      out_inval_d = (pend_status_q == ptmu_pkg::ST_DONE);
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccnt_q       <= '0;
      root_q       <= ptmu_pkg::ROOT_RESET;
      next_frame_q <= ptmu_pkg::FIRST_FREE_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      ccnt_q       <= ccnt_d;
      root_q       <= root_d;
      next_frame_q <= next_frame_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    va_q          <= va_d;
    pa_q          <= pa_d;
    level_q       <= level_d;
    frame_q       <= frame_d;
    made_q        <= made_d;
    nf_q          <= nf_d;
    zcnt_q        <= zcnt_d;
    pend_status_q <= pend_status_d;
    out_status_q  <= out_status_d;
    out_old_q     <= out_old_d;
    out_made_q    <= out_made_d;
    out_inval_q   <= out_inval_d;
  end

  assign rsp_valid_o           = out_valid_q;
  assign rsp_status_o          = out_status_q;
  assign rsp_old_phys_o        = out_old_q;
  assign rsp_tables_made_o     = out_made_q;
  assign rsp_invalidate_page_o = out_inval_q;

endmodule

// ----- sv/page_table_map_unmap.sv -----
// A request whose levels are all present passes through accept, root check, four store
// read/evaluate pairs and result load; each new table is first zeroed, all 512 entries
// through the single store write port, and then linked.
// Throughput: one request at a time; the next is accepted while a result waits.
// Reset: a clearing pass writes zero to all 8192 store entries, one per cycle,
// before the first request is accepted; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// page_table_map_unmap: four-level page table map/unmap engine
// Joins the walk controller and the datapath to the request, response and
// configuration ports.
// ----------------------------------------------------------------------------
module page_table_map_unmap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ptmu_req_if.sink                       req_i,
  ptmu_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [ptmu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptmu_pkg::CFG_W-1:0]     cfg_data_i
);

  ptmu_pkg::ctrl_cmd_t cmd;
  ptmu_pkg::dp_stat_t  stat;
  ptmu_pkg::status_e   rsp_status;
  logic                req_ready;

  // Walk controller.
  ptmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath with store and result register.
  ptmu_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .req_operation_i       (req_i.operation),
    .req_vaddr_i           (req_i.vaddr),
    .req_paddr_i           (req_i.paddr),
    .rsp_ready_i           (rsp_o.ready),
    .rsp_valid_o           (rsp_o.valid),
    .rsp_status_o          (rsp_status),
    .rsp_old_phys_o        (rsp_o.old_phys),
    .rsp_tables_made_o     (rsp_o.tables_made),
    .rsp_invalidate_page_o (rsp_o.invalidate_page)
  );

  assign req_i.ready  = req_ready;
  assign rsp_o.status = rsp_status;

`ifndef SYNTH
  // Only one request is in flight: ready drops right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // A failed walk neither returns an address nor asks for invalidation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ptmu_pkg::ST_DONE) |->
      !rsp_o.invalidate_page && (rsp_o.old_phys == '0))
    else $error("failed walk reports leaf data");

  // A completed walk always touched the leaf entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == ptmu_pkg::ST_DONE) |-> rsp_o.invalidate_page)
    else $error("completed walk without invalidation");

  // The returned address field has its page offset clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.old_phys[11:0] == 12'd0))
    else $error("returned address has offset bits set");
`endif

endmodule
